[sv/gdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

    // Defaults and fixed field widths
    localparam int MAX_VERTS_DEF = 64;
    localparam int NV_W          = 7;
    localparam int CNT_W         = 7;
    localparam int VTX_W         = 6;
    localparam int TOT_W         = 8;

    localparam logic [NV_W-1:0] NUM_VERTS_RESET = 7'd64;

    // Input actions
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_EDGE   = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_CLEARED  = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;
    localparam logic [1:0] KIND_REPORT   = 2'd3;

    typedef struct packed {
        logic [1:0]      action;
        logic [NV_W-1:0] from_vertex;
        logic [NV_W-1:0] to_vertex;
    } gdc_in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VTX_W-1:0] vertex;
        logic [CNT_W-1:0] in_degree;
        logic [CNT_W-1:0] out_degree;
        logic [TOT_W-1:0] total_degree;
        logic             last;
    } gdc_out_t;

    // Per-cycle command to one memory
    typedef struct packed {
        logic clr;
        logic rd;
        logic wr;
    } gdc_mem_cmd_t;

endpackage

`default_nettype wire

[sv/gdc_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module gdc_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire gdc_pkg::gdc_mem_cmd_t    cmd,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    import gdc_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    // Storage and registered read port; no reset on the array
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entry valid bits: an entry never written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

[sv/gdc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module gdc_ctrl #(
    parameter int MAX_VERTS = gdc_pkg::MAX_VERTS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic [gdc_pkg::NV_W-1:0]                   num_vertices,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire gdc_pkg::gdc_in_t                           in_data,
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output gdc_pkg::gdc_out_t                               out_data,
    output gdc_pkg::gdc_mem_cmd_t                           row_cmd,
    output logic [$clog2(MAX_VERTS)-1:0]                    row_wr_addr,
    output logic [MAX_VERTS+gdc_pkg::CNT_W-1:0]             row_wr_data,
    output logic [$clog2(MAX_VERTS)-1:0]                    row_rd_addr,
    input  wire logic [MAX_VERTS+gdc_pkg::CNT_W-1:0]        row_rd_data,
    output gdc_pkg::gdc_mem_cmd_t                           cnt_cmd,
    output logic [$clog2(MAX_VERTS)-1:0]                    cnt_wr_addr,
    output logic [gdc_pkg::CNT_W-1:0]                       cnt_wr_data,
    output logic [$clog2(MAX_VERTS)-1:0]                    cnt_rd_addr,
    input  wire logic [gdc_pkg::CNT_W-1:0]                  cnt_rd_data
);
    import gdc_pkg::*;

    localparam int VW = $clog2(MAX_VERTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EDGE,
        S_HOLD,
        S_REPORT
    } state_t;

    state_t          state_reg, state_next;
    logic [VW-1:0]   src_reg, src_next;
    logic [VW-1:0]   dst_reg, dst_next;
    logic [VW-1:0]   cur_v_reg, cur_v_next;
    logic [1:0]      pend_kind_reg, pend_kind_next;
    logic            out_valid_reg, out_valid_next;
    gdc_out_t        out_word_reg, out_word_next;

    logic                 out_free;
    logic                 out_load;
    logic                 emit_single;
    logic [1:0]           emit_kind;
    logic                 edge_bad;
    logic                 rep_last;
    logic [MAX_VERTS-1:0] row_q;
    logic [CNT_W-1:0]     out_cnt_q;

    assign out_free  = !out_valid_reg || out_ready;
    assign edge_bad  = (in_data.from_vertex >= num_vertices)
                       || (in_data.to_vertex >= num_vertices);
    assign rep_last  = ((NV_W'(cur_v_reg) + NV_W'(1)) == num_vertices);
    assign row_q     = row_rd_data[MAX_VERTS-1:0];
    assign out_cnt_q = row_rd_data[MAX_VERTS+CNT_W-1:MAX_VERTS];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cur_v_next     = cur_v_reg;
        pend_kind_next = pend_kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        out_load       = 1'b0;
        emit_single    = 1'b0;
        emit_kind      = KIND_CLEARED;

        row_cmd     = '0;
        cnt_cmd     = '0;
        row_rd_addr = in_data.from_vertex[VW-1:0];
        cnt_rd_addr = in_data.to_vertex[VW-1:0];
        row_wr_addr = src_reg;
        cnt_wr_addr = dst_reg;
        row_wr_data = {out_cnt_q + CNT_W'(1), row_q | (MAX_VERTS'(1) << dst_reg)};
        cnt_wr_data = cnt_rd_data + CNT_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.action)
                        ACT_CLEAR:
                        begin
                            row_cmd.clr = 1'b1;
                            cnt_cmd.clr = 1'b1;
                            emit_single = 1'b1;
                            emit_kind   = KIND_CLEARED;
                        end
                        ACT_EDGE:
                        begin
                            if (edge_bad)
                            begin
                                emit_single = 1'b1;
                                emit_kind   = KIND_REJECTED;
                            end
                            else
                            begin
                                row_cmd.rd = 1'b1;
                                cnt_cmd.rd = 1'b1;
                                src_next   = in_data.from_vertex[VW-1:0];
                                dst_next   = in_data.to_vertex[VW-1:0];
                                state_next = S_EDGE;
                            end
                        end
                        ACT_REPORT:
                        begin
                            row_rd_addr = '0;
                            cnt_rd_addr = '0;
                            row_cmd.rd  = 1'b1;
                            cnt_cmd.rd  = 1'b1;
                            cur_v_next  = '0;
                            state_next  = S_REPORT;
                        end
                        default:
                        begin
                            // unused action: drop it
                        end
                    endcase
                end
            end
            S_EDGE:
            begin
                // set the bit and bump both counters only for a new edge
                if (!row_q[dst_reg])
                begin
                    row_cmd.wr = 1'b1;
                    cnt_cmd.wr = 1'b1;
                end
                emit_single = 1'b1;
                emit_kind   = KIND_ACCEPTED;
            end
            S_HOLD:
            begin
                emit_single = 1'b1;
                emit_kind   = pend_kind_reg;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_valid_next             = 1'b1;
                    out_word_next.kind         = KIND_REPORT;
                    out_word_next.vertex       = VTX_W'(cur_v_reg);
                    out_word_next.in_degree    = cnt_rd_data;
                    out_word_next.out_degree   = out_cnt_q;
                    out_word_next.total_degree = TOT_W'(cnt_rd_data) + TOT_W'(out_cnt_q);
                    out_word_next.last         = rep_last;
                    if (rep_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance to the next vertex, read lands next cycle
                        cur_v_next  = cur_v_reg + VW'(1);
                        row_rd_addr = cur_v_reg + VW'(1);
                        cnt_rd_addr = cur_v_reg + VW'(1);
                        row_cmd.rd  = 1'b1;
                        cnt_cmd.rd  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_single)
        begin
            if (out_free)
            begin
                out_load                   = 1'b1;
                out_valid_next             = 1'b1;
                out_word_next.kind         = emit_kind;
                out_word_next.vertex       = '0;
                out_word_next.in_degree    = '0;
                out_word_next.out_degree   = '0;
                out_word_next.total_degree = '0;
                out_word_next.last         = 1'b1;
                state_next                 = S_IDLE;
            end
            else
            begin
                // hold the result until the output register drains
                pend_kind_next = emit_kind;
                state_next     = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        cur_v_reg     <= cur_v_next;
        pend_kind_reg <= pend_kind_next;
        out_word_reg  <= out_word_next;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before it was taken");

    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT && out_load && rep_last) |=> (state_reg == S_IDLE))
        else $error("report run did not end on its last vertex");

    a_row_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(row_cmd.wr && (row_cmd.rd || row_cmd.clr)))
        else $error("row memory write overlaps a read or clear");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.total_degree
            == TOT_W'(out_word_reg.in_degree) + TOT_W'(out_word_reg.out_degree)))
        else $error("total degree does not match its parts");

endmodule

`default_nettype wire

[sv/graph_degree_counter_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data  (gdc_in_t: action, from/to vertex)
// out       output     out_valid / out_ready  out_data (gdc_out_t: kind, vertex, degrees, last)
// cfg       input      cfg_wr_en              cfg_wr_data (num_vertices, 7 bits)
//
// Steps: a clear, a rejected edge or an unused action is handled in the idle
// state; an accepted edge reads the row/out-count word and the in-count word,
// then writes them back for a new edge. A report issues the first read, then
// gives one word per cycle when not stalled, from the registered read ports of both memories.
// Reset: no clearing pass; per-entry valid bits in each memory clear at once on
// reset and on a clear word, and an entry not written since reads as zero.
// Stalls: a finished word waits in the output register while the next input
// word is taken; a full output register holds the walk or the pending result.

module graph_degree_counter_core #(
    parameter int MAX_VERTS = gdc_pkg::MAX_VERTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire gdc_pkg::gdc_in_t         in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output gdc_pkg::gdc_out_t             out_data,
    input  wire logic                     cfg_wr_en,
    input  wire logic [gdc_pkg::NV_W-1:0] cfg_wr_data
);
    import gdc_pkg::*;

    localparam int              VW     = $clog2(MAX_VERTS);
    localparam int              ROW_W  = MAX_VERTS + CNT_W;
    localparam logic [NV_W-1:0] N_MAX  = NV_W'(MAX_VERTS);

    // Raw register as written; the count in use is clamped to 1..MAX_VERTS
    logic [NV_W-1:0] num_verts_reg;
    logic [NV_W-1:0] num_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_verts_reg <= NUM_VERTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            num_verts_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        priority if (num_verts_reg == '0)
        begin
            num_active = NV_W'(1);
        end
        else if (num_verts_reg > N_MAX)
        begin
            num_active = N_MAX;
        end
        else
        begin
            num_active = num_verts_reg;
        end
    end

    gdc_mem_cmd_t     row_cmd;
    logic [VW-1:0]    row_wr_addr;
    logic [ROW_W-1:0] row_wr_data;
    logic [VW-1:0]    row_rd_addr;
    logic [ROW_W-1:0] row_rd_data;
    gdc_mem_cmd_t     cnt_cmd;
    logic [VW-1:0]    cnt_wr_addr;
    logic [CNT_W-1:0] cnt_wr_data;
    logic [VW-1:0]    cnt_rd_addr;
    logic [CNT_W-1:0] cnt_rd_data;

    // Sequencer: edge read-modify-write, report walk, output register
    gdc_ctrl #(
        .MAX_VERTS (MAX_VERTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .num_vertices (num_active),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .row_cmd      (row_cmd),
        .row_wr_addr  (row_wr_addr),
        .row_wr_data  (row_wr_data),
        .row_rd_addr  (row_rd_addr),
        .row_rd_data  (row_rd_data),
        .cnt_cmd      (cnt_cmd),
        .cnt_wr_addr  (cnt_wr_addr),
        .cnt_wr_data  (cnt_wr_data),
        .cnt_rd_addr  (cnt_rd_addr),
        .cnt_rd_data  (cnt_rd_data)
    );

    // Row memory, indexed by source vertex: {out-degree, adjacency row}
    gdc_mem #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VERTS)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (row_cmd),
        .wr_addr (row_wr_addr),
        .wr_data (row_wr_data),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    // In-degree memory, indexed by destination vertex
    gdc_mem #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_VERTS)
    ) u_cnt_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cnt_cmd),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

endmodule

`default_nettype wire

[test/graph_degree_counter_checker.sv]
`timescale 1ns / 1ps

module graph_degree_counter_checker
    import gdc_pkg::*;
#(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire gdc_in_t         in_data,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire gdc_out_t        out_data,
    input  wire logic            cfg_wr_en,
    input  wire logic [NV_W-1:0] cfg_wr_data,
    output int                   mismatches,
    output int                   backlog
);

    // Shadow copy of the graph: adjacency rows and per-vertex degree counters
    logic [MAX_VERTS-1:0] adj_rows [MAX_VERTS];
    logic [CNT_W-1:0]     in_deg   [MAX_VERTS];
    logic [CNT_W-1:0]     out_deg  [MAX_VERTS];
    logic [NV_W-1:0]      vert_setting;
    gdc_out_t             degree_results_q [$];
    gdc_out_t             want;

    function automatic int vertices_in_use(logic [NV_W-1:0] setting);
        if (setting == 0)
        begin
            return 1;
        end
        if (setting > MAX_VERTS)
        begin
            return MAX_VERTS;
        end
        return int'(setting);
    endfunction

    function automatic gdc_out_t status_word(logic [1:0] k);
        gdc_out_t r;
        r      = '0;
        r.kind = k;
        r.last = 1'b1;
        return r;
    endfunction

    // Field list of one result word for messages
    function automatic string fmt_word(gdc_out_t w);
        return $sformatf("kind=%0d vertex=%0d in=%0d out=%0d total=%0d last=%0d",
                         w.kind, w.vertex, w.in_degree, w.out_degree,
                         w.total_degree, w.last);
    endfunction

    task automatic clear_graph;
        for (int v = 0; v < MAX_VERTS; v++)
        begin
            adj_rows[v] = '0;
            in_deg[v]   = '0;
            out_deg[v]  = '0;
        end
    endtask

    task automatic predict_word(gdc_in_t w);
        int       n;
        gdc_out_t r;
        n = vertices_in_use(vert_setting);
        case (w.action)
            ACT_CLEAR:
            begin
                clear_graph();
                degree_results_q.push_back(status_word(KIND_CLEARED));
            end
            ACT_EDGE:
            begin
                if (w.from_vertex >= n || w.to_vertex >= n)
                begin
                    degree_results_q.push_back(status_word(KIND_REJECTED));
                end
                else
                begin
                    // count a new edge only once
                    if (!adj_rows[w.from_vertex][w.to_vertex])
                    begin
                        adj_rows[w.from_vertex][w.to_vertex] = 1'b1;
                        in_deg[w.to_vertex]    = in_deg[w.to_vertex] + 1'b1;
                        out_deg[w.from_vertex] = out_deg[w.from_vertex] + 1'b1;
                    end
                    degree_results_q.push_back(status_word(KIND_ACCEPTED));
                end
            end
            ACT_REPORT:
            begin
                for (int v = 0; v < n; v++)
                begin
                    r              = '0;
                    r.kind         = KIND_REPORT;
                    r.vertex       = VTX_W'(v);
                    r.in_degree    = in_deg[v];
                    r.out_degree   = out_deg[v];
                    r.total_degree = TOT_W'(in_deg[v]) + TOT_W'(out_deg[v]);
                    r.last         = (v == n - 1);
                    degree_results_q.push_back(r);
                end
            end
            default:
            begin
                // unused action: drop it
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_graph();
            vert_setting = NUM_VERTS_RESET;
            degree_results_q.delete();
            backlog = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vert_setting = cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                predict_word(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (degree_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result word %s", $time, fmt_word(out_data));
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = degree_results_q.pop_front();
                    if (out_data !== want)
                    begin
                        $display("%0t: mismatch expected %s", $time, fmt_word(want));
                        $display("%0t:          actual   %s", $time, fmt_word(out_data));
                        mismatches = mismatches + 1;
                    end
                end
            end
            backlog = degree_results_q.size();
        end
    end

endmodule

[test/graph_degree_counter_core_tb.sv]
`timescale 1ns / 1ps

module graph_degree_counter_core_tb;
    import gdc_pkg::*;

    // Action code the block ignores; the package names only the three in use
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Quiet cycles (no word moved on either channel) before the run is called hung
    localparam int QUIET_LIMIT = 2000;

    // Random part: phases, each with its own vertex count, and counted words per phase
    localparam int RANDOM_PHASES    = 10;
    localparam int WORDS_PER_PHASE  = 12;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            in_valid    = 1'b0;
    logic            in_ready;
    gdc_in_t         in_data     = '0;
    logic            out_valid;
    logic            out_ready   = 1'b0;
    gdc_out_t        out_data;
    logic            cfg_wr_en   = 1'b0;
    logic [NV_W-1:0] cfg_wr_data = '0;

    int mismatches;
    int backlog;
    int quiet_cycles = 0;
    int stall_left   = 0;

    // Idling switches, flipped per phase so some stretches run at full rate
    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;

    // Vertex count in use, kept only to shape the stimulus
    int cur_n = 64;

    always #2 clk = ~clk;

    graph_degree_counter_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    graph_degree_counter_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .backlog     (backlog)
    );

    // Pause length: mostly short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    // Receiver side: drop ready for random stretches, hold it high otherwise
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 99) < 20)
        begin
            stall_left = pick_pause() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one word at a falling edge, hold it until taken, then maybe pause.
    // Valid stays high into the next word when no pause is drawn.
    task automatic send_word(input logic [1:0] act, input logic [NV_W-1:0] src,
                             input logic [NV_W-1:0] dst);
        int gap;
        in_valid <= 1'b1;
        in_data  <= gdc_in_t'{action: act, from_vertex: src, to_vertex: dst};
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        gap = (gaps_on && $urandom_range(0, 99) < 45) ? pick_pause() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid, wait for every expected result, then let an ignored word finish
    task automatic drain;
        in_valid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the vertex count while the block is idle
    task automatic set_vertices(input logic [NV_W-1:0] setting);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_n = (setting == 0) ? 1 : ((setting > 64) ? 64 : int'(setting));
    endtask

    function automatic logic [NV_W-1:0] phase_setting(int ph);
        case (ph)
            0:       return 7'd2;
            1:       return 7'd64;
            2:       return 7'd9;
            3:       return 7'd1;
            4:       return 7'd33;
            5:       return 7'd127;
            6:       return 7'd0;
            7:       return 7'd16;
            8:       return 7'd64;
            default: return NV_W'($urandom_range(1, 127));
        endcase
    endfunction

    // One random word. Mostly valid edges, with a hot corner of low vertices so
    // repeats happen, plus out-of-range edges, reports, clears and noise.
    task automatic send_random_word(output bit counted);
        int              r;
        int              p;
        int              hot;
        logic [NV_W-1:0] src;
        logic [NV_W-1:0] dst;
        r   = $urandom_range(0, 99);
        src = NV_W'($urandom_range(0, 127));
        dst = NV_W'($urandom_range(0, 127));
        counted = 1'b1;
        if (r < 4)
        begin
            send_word(ACT_CLEAR, src, dst);
        end
        else if (r < 11)
        begin
            send_word(ACT_REPORT, src, dst);
        end
        else if (r < 15)
        begin
            counted = 1'b0;
            send_word(ACT_UNUSED, src, dst);
        end
        else
        begin
            p   = $urandom_range(0, 99);
            hot = (cur_n < 4) ? cur_n : 4;
            if (p < 55)
            begin
                src = NV_W'($urandom_range(0, cur_n - 1));
                dst = NV_W'($urandom_range(0, cur_n - 1));
            end
            else if (p < 75)
            begin
                src = NV_W'($urandom_range(0, hot - 1));
                dst = NV_W'($urandom_range(0, hot - 1));
            end
            else if (p < 90)
            begin
                src = NV_W'($urandom_range(0, cur_n - 1));
                dst = NV_W'($urandom_range(0, cur_n - 1));
                if ($urandom_range(0, 1))
                begin
                    src = NV_W'($urandom_range(cur_n, 127));
                end
                else
                begin
                    dst = NV_W'($urandom_range(cur_n, 127));
                end
            end
            send_word(ACT_EDGE, src, dst);
        end
    endtask

    initial
    begin
        int done;
        bit counted;

        // Hold reset, then release it at a falling edge
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at full rate, reset vertex count of 64
        send_word(ACT_CLEAR, 7'd127, 7'd127);   // don't-care fields set high
        send_word(ACT_EDGE, 7'd0, 7'd0);        // self-loop
        send_word(ACT_EDGE, 7'd0, 7'd0);        // repeated self-loop, no count
        send_word(ACT_EDGE, 7'd63, 7'd63);
        send_word(ACT_EDGE, 7'd0, 7'd63);
        send_word(ACT_EDGE, 7'd63, 7'd0);
        send_word(ACT_EDGE, 7'd0, 7'd63);       // repeated edge
        send_word(ACT_EDGE, 7'd64, 7'd0);       // source just out of range
        send_word(ACT_EDGE, 7'd0, 7'd64);       // destination just out of range
        send_word(ACT_EDGE, 7'd127, 7'd127);
        send_word(ACT_UNUSED, 7'd127, 7'd127);  // ignored, no result
        send_word(ACT_REPORT, 7'd0, 7'd0);

        set_vertices(7'd0);                     // zero behaves as one vertex
        send_word(ACT_EDGE, 7'd0, 7'd1);
        send_word(ACT_EDGE, 7'd0, 7'd0);
        send_word(ACT_REPORT, 7'd127, 7'd127);

        set_vertices(7'd127);                   // above the maximum, clamps to 64
        send_word(ACT_EDGE, 7'd42, 7'd21);
        send_word(ACT_EDGE, 7'd63, 7'd64);

        set_vertices(7'd5);                     // lowered count keeps stored edges
        send_word(ACT_EDGE, 7'd4, 7'd5);
        send_word(ACT_EDGE, 7'd4, 7'd0);
        send_word(ACT_REPORT, 7'd0, 7'd0);

        set_vertices(7'd64);                    // raised again, old edges reappear
        send_word(ACT_REPORT, 7'd0, 7'd0);
        send_word(ACT_CLEAR, 7'd0, 7'd0);
        send_word(ACT_REPORT, 7'd0, 7'd0);

        // Random part: one vertex count per phase, idling switched per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_vertices(phase_setting(ph));
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            done = 0;
            while (done < WORDS_PER_PHASE)
            begin
                send_random_word(counted);
                done = done + int'(counted);
            end
        end

        // Wait out every result and the block's last cycles, then give the verdict
        drain();
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
